FILE: rtl/pcxd_pkg.sv
package pcxd_pkg;

    localparam int unsigned PALETTE_ENTRIES_DEF = 256;

    localparam int DIM_W      = 17;
    localparam int CNT_W      = 33;
    localparam int RUN_W      = 6;
    localparam int BYTE_W     = 8;
    localparam int COLOR_W    = 24;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 24;
    localparam int OUT_USER_W = 2;
    localparam int APB_AW     = 3;
    localparam int APB_DW     = 32;

    // Bytes above this value are run markers
    localparam logic [BYTE_W-1:0] RUN_MARK = 8'hBF;

    localparam logic [DIM_W-1:0] DIM_MIN = 17'd1;
    localparam logic [DIM_W-1:0] DIM_MAX = 17'd65536;

    // Input item kinds (tuser)
    localparam logic CMD_DATA    = 1'b0;
    localparam logic CMD_PALETTE = 1'b1;

    // Register indexes (paddr[2])
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef struct packed {
        logic accept;   // input beat taken this cycle
        logic check;    // clip the pending run against the image size
        logic emit;     // load one pixel into the output register
    } t_cmd;

    typedef struct packed {
        logic starts;   // the offered data byte opens a non-empty run
        logic n_zero;   // clipped run has no pixels left
        logic last;     // the pixel being loaded is the last of the run
        logic out_free; // output register can take a pixel
    } t_stat;

endpackage

FILE: rtl/pcxd_cfg.sv
module pcxd_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pcxd_pkg::APB_AW-1:0]   paddr,
    input  logic [pcxd_pkg::APB_DW-1:0]   pwdata,
    output logic [pcxd_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    output logic [pcxd_pkg::CNT_W-1:0]    o_total
);
    import pcxd_pkg::*;

    logic [DIM_W-1:0]   r_width;
    logic [DIM_W-1:0]   r_height;
    logic [CNT_W-1:0]   r_total;
    logic [DIM_W-1:0]   w_width_c;
    logic [DIM_W-1:0]   w_height_c;
    logic [2*DIM_W-1:0] w_prod;
    logic               w_wr;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        r = v;
        if (v < DIM_MIN) r = DIM_MIN;
        if (v > DIM_MAX) r = DIM_MAX;
        return r;
    endfunction

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= DIM_MIN;
            r_height <= DIM_MIN;
        end else if (w_wr) begin
            if (paddr[2] == REG_WIDTH) begin
                r_width <= pwdata[DIM_W-1:0];
            end else begin
                r_height <= pwdata[DIM_W-1:0];
            end
        end
    end

    always_comb begin
        case (paddr[2])
            REG_WIDTH:  prdata = {{(APB_DW-DIM_W){1'b0}}, r_width};
            REG_HEIGHT: prdata = {{(APB_DW-DIM_W){1'b0}}, r_height};
            default:    prdata = '0;
        endcase
    end

    // Pixel total, refreshed every cycle; at most 2^32 so it fits the count width
    assign w_width_c  = clamp_dim(r_width);
    assign w_height_c = clamp_dim(r_height);
    assign w_prod     = {{DIM_W{1'b0}}, w_width_c} * {{DIM_W{1'b0}}, w_height_c};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= CNT_W'(1);
        end else begin
            r_total <= w_prod[CNT_W-1:0];
        end
    end

    assign o_total = r_total;

endmodule

FILE: rtl/pcxd_ctrl.sv
module pcxd_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_tvalid,
    output logic            o_tready,
    input  pcxd_pkg::t_stat i_stat,
    output pcxd_pkg::t_cmd  o_cmd
);
    import pcxd_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_CHECK = 3'b010,
        S_EMIT  = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_tready = (r_state == S_IDLE);

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_cmd.accept = i_tvalid & o_tready;
        case (r_state)
            S_IDLE: begin
                if (i_tvalid && i_stat.starts) n_state = S_CHECK;
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                n_state     = i_stat.n_zero ? S_IDLE : S_EMIT;
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_stat.last) n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: rtl/pcxd_dp.sv
module pcxd_dp #(
    parameter int unsigned PALETTE_ENTRIES = pcxd_pkg::PALETTE_ENTRIES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  pcxd_pkg::t_cmd                   i_cmd,
    output pcxd_pkg::t_stat                  o_stat,
    input  logic [pcxd_pkg::IN_DATA_W-1:0]   i_tdata,
    input  logic                             i_tuser,
    input  logic [pcxd_pkg::CNT_W-1:0]       i_total,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [pcxd_pkg::OUT_DATA_W-1:0]  o_m_tdata,
    output logic                             o_m_tlast,
    output logic [pcxd_pkg::OUT_USER_W-1:0]  o_m_tuser
);
    import pcxd_pkg::*;

    localparam int AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
    localparam logic [BYTE_W:0] ENTRIES_N = (BYTE_W+1)'(PALETTE_ENTRIES);

    logic [BYTE_W-1:0]     w_byte;
    logic [BYTE_W-1:0]     w_pidx;
    logic [COLOR_W-1:0]    w_pcol;
    logic                  w_pidx_ok;
    logic                  w_byte_ok;
    logic                  w_starts;
    logic [RUN_W-1:0]      w_start_cnt;
    logic [CNT_W-1:0]      w_room;
    logic                  w_over;
    logic [CNT_W-1:0]      w_count_inc;

    logic [COLOR_W-1:0]    r_mem [PALETTE_ENTRIES];
    logic [COLOR_W-1:0]    r_rd_data;
    logic                  r_byte_ok;
    logic                  r_pending;
    logic [RUN_W-1:0]      r_len;
    logic [RUN_W-1:0]      r_remaining;
    logic [CNT_W-1:0]      r_count;
    logic                  r_overflow;
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic                  r_out_last;
    logic [OUT_USER_W-1:0] r_out_user;

    assign w_byte    = i_tdata[BYTE_W-1:0];
    assign w_pidx    = i_tdata[2*BYTE_W-1:BYTE_W];
    assign w_pcol    = i_tdata[IN_DATA_W-1:2*BYTE_W];
    assign w_pidx_ok = {1'b0, w_pidx} < ENTRIES_N;
    assign w_byte_ok = {1'b0, w_byte} < ENTRIES_N;

    // Palette table: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && i_tuser == CMD_PALETTE && w_pidx_ok) begin
            r_mem[w_pidx[AW-1:0]] <= w_pcol;
        end
        if (i_cmd.accept && i_tuser == CMD_DATA) begin
            r_rd_data <= r_mem[w_byte[AW-1:0]];
            r_byte_ok <= w_byte_ok;
        end
    end

    // Run decode of the offered byte
    always_comb begin
        w_starts    = 1'b0;
        w_start_cnt = RUN_W'(1);
        if (i_tuser == CMD_DATA) begin
            if (r_pending) begin
                w_starts    = (r_len != '0);
                w_start_cnt = r_len;
            end else if (w_byte <= RUN_MARK) begin
                w_starts = 1'b1;
            end
        end
    end

    // No room left once the count has reached a total that shrank under it
    assign w_room      = (r_count < i_total) ? (i_total - r_count) : '0;
    assign w_over      = w_room < {{(CNT_W-RUN_W){1'b0}}, r_remaining};
    assign w_count_inc = r_count + CNT_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending   <= 1'b0;
            r_len       <= '0;
            r_remaining <= '0;
            r_count     <= '0;
            r_overflow  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.accept && i_tuser == CMD_DATA) begin
                if (r_pending) begin
                    r_pending <= 1'b0;
                    r_len     <= '0;
                end else if (w_byte > RUN_MARK) begin
                    r_pending <= 1'b1;
                    r_len     <= w_byte[RUN_W-1:0];
                end
                if (w_starts) r_remaining <= w_start_cnt;
            end
            // Clip to the room left in the image
            if (i_cmd.check && w_over) begin
                r_overflow  <= 1'b1;
                r_remaining <= w_room[RUN_W-1:0];
            end
            if (i_cmd.emit) begin
                r_count     <= w_count_inc;
                r_remaining <= r_remaining - RUN_W'(1);
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_data <= r_byte_ok ?
                          {r_rd_data[7:0], r_rd_data[15:8], r_rd_data[23:16]} : '0;
            r_out_last <= (r_remaining == RUN_W'(1));
            r_out_user <= {r_overflow, (w_count_inc == i_total)};
        end
    end

    assign o_stat.starts   = w_starts;
    assign o_stat.n_zero   = w_over && (w_room == '0);
    assign o_stat.last     = (r_remaining == RUN_W'(1));
    assign o_stat.out_free = !r_out_valid || i_m_tready;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;
    assign o_m_tuser  = r_out_user;

endmodule

FILE: rtl/pcx_rle_palette_decoder.sv
// Channel  | Dir | Handshake                 | Payload
// ---------+-----+---------------------------+------------------------------------------
// s_axis   | in  | s_axis_tvalid/tready      | tdata: byte, palette index, color; tuser: kind
// m_axis   | out | m_axis_tvalid/tready      | tdata: red, green, blue; tlast; tuser: flags
// apb      | in  | psel/penable/pready       | 0x0 image width, 0x4 image height (17 bits)
//
// A palette write, a run marker or an empty run is accepted and leaves the sequencer idle.
// A data byte that yields pixels is accepted with a registered palette read, then
// clipped against the image size in S_CHECK; S_EMIT then loads one pixel per free
// slot into the single output register (run length after clipping, 1..63).
// Reset (synchronous, i_rst_n low) clears run state, pixel count and overflow;
// the palette keeps its contents and must be written before use.
// A stalled m_axis holds the pixel in the output register and pauses the run.
module pcx_rle_palette_decoder #(
    parameter int unsigned PALETTE_ENTRIES = pcxd_pkg::PALETTE_ENTRIES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // tdata: [7:0] data_byte, [15:8] palette_index, [39:16] palette_color
    input  logic [pcxd_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // tuser: [0] command (0 data byte, 1 palette write)
    input  logic                            s_axis_tuser,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // tdata: [7:0] red, [15:8] green, [23:16] blue
    output logic [pcxd_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // tuser: [0] image_done, [1] overflow_seen
    output logic [pcxd_pkg::OUT_USER_W-1:0] m_axis_tuser,
    output logic                            m_axis_tlast,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [pcxd_pkg::APB_AW-1:0]     paddr,
    input  logic [pcxd_pkg::APB_DW-1:0]     pwdata,
    output logic [pcxd_pkg::APB_DW-1:0]     prdata,
    output logic                            pready
);
    import pcxd_pkg::*;

    t_cmd             w_cmd;
    t_stat            w_stat;
    logic [CNT_W-1:0] w_total;

    // Register file and pixel total
    pcxd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_total (w_total)
    );

    // Sequencer: accept, clip, then one pixel per free output slot
    pcxd_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tvalid (s_axis_tvalid),
        .o_tready (s_axis_tready),
        .i_stat   (w_stat),
        .o_cmd    (w_cmd)
    );

    // Palette, run state, pixel count and output register
    pcxd_dp #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .i_tdata    (s_axis_tdata),
        .i_tuser    (s_axis_tuser),
        .i_total    (w_total),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_m_tdata  (m_axis_tdata),
        .o_m_tlast  (m_axis_tlast),
        .o_m_tuser  (m_axis_tuser)
    );

endmodule

FILE: rtl/pcxd_checker.sv
module pcxd_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic [pcxd_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input logic [pcxd_pkg::OUT_USER_W-1:0] m_axis_tuser,
    input logic                            m_axis_tlast,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready
);
    import pcxd_pkg::*;

    logic w_beat;
    logic r_ovf_seen;

    assign w_beat = m_axis_tvalid & m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovf_seen <= 1'b0;
        end else if (w_beat && m_axis_tuser[1]) begin
            r_ovf_seen <= 1'b1;
        end
    end

    // A stalled pixel stays offered
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("m_axis pixel dropped while stalled");

    // Reset leaves no pixel on the output
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("m_axis valid after reset");

    // The pixel that fills the image always ends its run
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_beat && m_axis_tuser[0] |-> m_axis_tlast)
        else $error("image done without run end");

    // Overflow flag never drops once shown
    a_ovf_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_beat && r_ovf_seen |-> m_axis_tuser[1])
        else $error("overflow flag cleared");

endmodule

bind pcx_rle_palette_decoder pcxd_checker u_pcxd_checker (.*);
